### rtl/sasrf_pkg.sv
package sasrf_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_WIDTH  = 32;

   // port field widths
   localparam int OP_W     = 2;
   localparam int FIELD_W  = 32;
   localparam int STATUS_W = 3;

   // table index and fill count
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // width for the forget range compare
   localparam int CMP_W = (ADDR_WIDTH > FIELD_W) ? ADDR_WIDTH : FIELD_W;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_MARK   = 2'd0;
   localparam op_type OP_FORGET = 2'd1;
   localparam op_type OP_CLEAR  = 2'd2;

   localparam status_type STAT_NEW   = 3'd0;
   localparam status_type STAT_SEEN  = 3'd1;
   localparam status_type STAT_NULL  = 3'd2;
   localparam status_type STAT_FULL  = 3'd3;
   localparam status_type STAT_MAINT = 3'd4;

endpackage

### rtl/sasrf_ram.sv
module sasrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/seen_address_set_range_forget.sv
// Seen-address set with range forget.
//
// req_ channel carries one operation per transaction: mark an address, forget
// every stored address in [addr, addr + range_size), or clear the set. The
// rsp_ channel returns exactly one transaction per request with do_action,
// status and the number of stored addresses after the operation.
//
// The set lives in one TABLE_DEPTH x ADDR_WIDTH memory with one read and one
// write port and a registered read; the fill count is a register.
// One request is in flight at a time; req_ready is high only while idle.
// Clear, null mark, null forget and an unused op go straight to the response.
// Mark scans the stored entries and stops early on a hit. Forget reads each
// entry and checks it; an entry in range is replaced by the last one, which
// is checked in turn. The single memory read port makes both scan serially.
// The response sits in an output register; while rsp_ready is low the
// finished transaction holds there and the next request waits in its done
// step. Reset empties the set by setting the fill count to zero; the memory
// itself is not cleared since only entries below the count are ever read.
module seen_address_set_range_forget (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sasrf_pkg::op_type                     req_op,
   input  logic [sasrf_pkg::FIELD_W-1:0]         req_addr,
   input  logic [sasrf_pkg::FIELD_W-1:0]         req_range_size,
   input  logic                                  req_has_handler,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_do_action,
   output sasrf_pkg::status_type                 rsp_status,
   output logic [sasrf_pkg::CNT_W-1:0]           rsp_entries_in_use
);
   import sasrf_pkg::*;

   localparam int FSM_W = 3;
   localparam logic [FSM_W-1:0] FSM_IDLE     = 3'd0;
   localparam logic [FSM_W-1:0] FSM_MK_SCAN  = 3'd1;
   localparam logic [FSM_W-1:0] FSM_FG_READ  = 3'd2;
   localparam logic [FSM_W-1:0] FSM_FG_CHECK = 3'd3;
   localparam logic [FSM_W-1:0] FSM_DONE     = 3'd4;

   logic [FSM_W-1:0]      state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [ADDR_WIDTH-1:0] key_ff, key_in;
   logic [FIELD_W-1:0]    size_ff, size_in;
   status_type            status_ff, status_in;
   logic                  act_ff, act_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_do_action_ff, rsp_do_action_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_wr_addr;
   logic [ADDR_WIDTH-1:0] mem_wr_data;
   logic [IDX_W-1:0]      mem_rd_addr;
   logic [ADDR_WIDTH-1:0] mem_rd_data;

   logic [ADDR_WIDTH-1:0] req_key;
   logic [ADDR_WIDTH-1:0] q_offset;
   logic                  in_range;
   logic                  hit;
   logic                  more;
   logic [CNT_W-1:0]      count_dec;

   sasrf_ram #(
      .WIDTH(ADDR_WIDTH),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   assign req_key   = ADDR_WIDTH'(req_addr);
   assign q_offset  = mem_rd_data - key_ff;
   assign in_range  = (mem_rd_data >= key_ff) && (CMP_W'(q_offset) < CMP_W'(size_ff));
   assign hit       = (mem_rd_data == key_ff);
   assign more      = (idx_ff < count_ff);
   assign count_dec = count_ff - 1'b1;

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      idx_in           = idx_ff;
      chk_vld_in       = 1'b0;
      key_in           = key_ff;
      size_in          = size_ff;
      status_in        = status_ff;
      act_in           = act_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_do_action_in = rsp_do_action_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_count_in     = rsp_count_ff;
      mem_we           = 1'b0;
      mem_wr_addr      = idx_ff[IDX_W-1:0];
      mem_wr_data      = mem_rd_data;
      mem_rd_addr      = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_valid) begin
               key_in    = req_key;
               size_in   = req_range_size;
               act_in    = 1'b0;
               status_in = STAT_MAINT;
               idx_in    = '0;
               state_in  = FSM_DONE;
               unique case (req_op)
                  OP_MARK: begin
                     if (req_key == '0 || !req_has_handler) begin
                        status_in = STAT_NULL;
                     end else begin
                        state_in = FSM_MK_SCAN;
                     end
                  end
                  OP_FORGET: begin
                     if (req_key != '0 && req_range_size != '0) begin
                        state_in = FSM_FG_READ;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         FSM_MK_SCAN: begin
            // issue one read per cycle, compare the one returned
            if (more) begin
               idx_in     = idx_ff + 1'b1;
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff && hit) begin
               chk_vld_in = 1'b0;
               status_in  = STAT_SEEN;
               state_in   = FSM_DONE;
            end else if (!more && !chk_vld_ff) begin
               if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                  status_in = STAT_FULL;
               end else begin
                  mem_we      = 1'b1;
                  mem_wr_addr = count_ff[IDX_W-1:0];
                  mem_wr_data = key_ff;
                  count_in    = count_ff + 1'b1;
                  status_in   = STAT_NEW;
                  act_in      = 1'b1;
               end
               state_in = FSM_DONE;
            end
         end
         FSM_FG_READ: begin
            if (more) begin
               state_in = FSM_FG_CHECK;
            end else begin
               state_in = FSM_DONE;
            end
         end
         FSM_FG_CHECK: begin
            // rd_data is the entry now at idx; write it back so a moved
            // last entry lands here, then drop it too if it falls in range
            if (!more) begin
               state_in = FSM_DONE;
            end else begin
               mem_we = 1'b1;
               if (in_range) begin
                  count_in    = count_dec;
                  mem_rd_addr = count_dec[IDX_W-1:0];
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = FSM_FG_READ;
               end
            end
         end
         FSM_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_do_action_in = act_ff;
               rsp_status_in    = status_ff;
               rsp_count_in     = count_ff;
               state_in         = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff           <= idx_in;
      key_ff           <= key_in;
      size_ff          <= size_in;
      status_ff        <= status_in;
      act_ff           <= act_in;
      rsp_do_action_ff <= rsp_do_action_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign req_ready          = (state_ff == FSM_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_do_action      = rsp_do_action_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entries_in_use = rsp_count_ff;

endmodule

### rtl/sasrf_checker.sv
module sasrf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input sasrf_pkg::op_type           req_op,
   input logic [sasrf_pkg::FIELD_W-1:0] req_addr,
   input logic [sasrf_pkg::FIELD_W-1:0] req_range_size,
   input logic                        req_has_handler,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_do_action,
   input sasrf_pkg::status_type       rsp_status,
   input logic [sasrf_pkg::CNT_W-1:0] rsp_entries_in_use
);
   import sasrf_pkg::*;

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_do_action)
         && $stable(rsp_status) && $stable(rsp_entries_in_use))
      else $error("response changed while stalled");

   a_action_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_do_action == (rsp_status == STAT_NEW)))
      else $error("do_action disagrees with status");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |-> rsp_entries_in_use == CNT_W'(TABLE_DEPTH))
      else $error("full status with free entries");

   a_new_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_NEW |-> rsp_entries_in_use != '0)
      else $error("new mark left the set empty");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in flight");

endmodule

bind seen_address_set_range_forget sasrf_checker u_sasrf_checker (.*);
